[hdl/frwa_pkg.sv]
// ----------------------------------------------------------------------------
// frwa_pkg
// Shared types, widths and constants of the fuel rate window adjuster.
// ----------------------------------------------------------------------------
package frwa_pkg;

  // Ring depth and derived widths
  localparam int unsigned WINDOW_DEPTH = 64;
  localparam int unsigned SLOT_W       = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int unsigned WIN_W        = $clog2(WINDOW_DEPTH + 1);

  // Field widths
  localparam int unsigned CFG_WIN_W = 7;
  localparam int unsigned MAX_W     = 40;
  localparam int unsigned RATE_W    = 32;
  localparam int unsigned HEIGHT_W  = 31;
  localparam int unsigned STEP_W    = 39;

  // Window sum and shared divider widths
  localparam int unsigned SUM_W = STEP_W + $clog2(WINDOW_DEPTH);
  localparam int unsigned DVD_W = SUM_W;
  localparam int unsigned DSR_W = RATE_W;
  localparam int unsigned CMP_W = ((SUM_W > MAX_W) ? SUM_W : MAX_W) + 5;
  localparam int unsigned EXT_W = (WIN_W > CFG_WIN_W) ? WIN_W : CFG_WIN_W;

  // Rate / 10 as (rate * RECIP10) >> RECIP10_SH, exact for any 32-bit rate
  localparam logic [RATE_W-1:0] RECIP10    = 32'hCCCC_CCCD;
  localparam int unsigned       RECIP10_SH = 35;

  // APB port
  localparam int unsigned APB_AW = 5;
  localparam int unsigned APB_DW = 64;

  // Register reset values
  localparam logic [CFG_WIN_W-1:0] WINDOW_RST   = CFG_WIN_W'(50);
  localparam logic [MAX_W-1:0]     MAX_STEP_RST = MAX_W'(12000000);
  localparam logic [RATE_W-1:0]    INIT_RST     = RATE_W'(100);
  localparam logic [RATE_W-1:0]    MIN_RST      = RATE_W'(1);

  typedef enum logic [1:0] {
    REG_WINDOW    = 2'd0,
    REG_MAX_STEP  = 2'd1,
    REG_INIT_RATE = 2'd2,
    REG_MIN_RATE  = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    ACT_INITIAL = 2'd0,
    ACT_LOWERED = 2'd1,
    ACT_RAISED  = 2'd2,
    ACT_KEPT    = 2'd3
  } action_e;

  typedef struct packed {
    logic [HEIGHT_W-1:0] block_height;
    logic [RATE_W-1:0]   block_fuel;
    logic [RATE_W-1:0]   block_rate;
  } in_req_t;

  typedef struct packed {
    logic [RATE_W-1:0] next_rate;
    action_e           rate_action;
    logic              hit_minimum;
  } out_rsp_t;

  typedef struct packed {
    logic [CFG_WIN_W-1:0] window_blocks;
    logic [MAX_W-1:0]     max_run_step;
    logic [RATE_W-1:0]    initial_rate;
    logic [RATE_W-1:0]    minimum_rate;
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DSR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quot;
  } div_rsp_t;

  // Window register clamped to 1..WINDOW_DEPTH
  function automatic logic [WIN_W-1:0] eff_window(input logic [CFG_WIN_W-1:0] w);
    logic [EXT_W-1:0] wx;
    wx = EXT_W'(w);
    if (wx == '0) begin
      wx = EXT_W'(1);
    end else if (wx > EXT_W'(WINDOW_DEPTH)) begin
      wx = EXT_W'(WINDOW_DEPTH);
    end
    return WIN_W'(wx);
  endfunction

  // q * 100 as shifts and adds (64 + 32 + 4)
  function automatic logic [STEP_W-1:0] times100(input logic [RATE_W-1:0] q);
    return STEP_W'({q, 6'b0}) + STEP_W'({q, 5'b0}) + STEP_W'({q, 2'b0});
  endfunction

endpackage

[hdl/frwa_ram.sv]
// ----------------------------------------------------------------------------
// frwa_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module frwa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/frwa_div.sv]
// ----------------------------------------------------------------------------
// frwa_div
// Restoring radix-2 divider, one quotient bit per cycle, shared by the
// step and window average divisions.
// ----------------------------------------------------------------------------
module frwa_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  frwa_pkg::div_req_t  req_i,
  output frwa_pkg::div_rsp_t  rsp_o
);
  import frwa_pkg::*;

  localparam int unsigned CNT_W = $clog2(DVD_W + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DVD_W-1:0] quo_q, quo_d;
  logic [DSR_W-1:0] rem_q, rem_d;
  logic [DSR_W-1:0] dsr_q, dsr_d;

  logic [DSR_W:0]   rem_sh;
  logic [DSR_W:0]   rem_sub;
  logic             ge;

  // One shift-subtract step
  assign rem_sh  = {rem_q, quo_q[DVD_W-1]};
  assign ge      = rem_sh >= {1'b0, dsr_q};
  assign rem_sub = rem_sh - {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(DVD_W);
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dsr_d  = req_i.divisor;
    end else if (busy_q) begin
      quo_d = {quo_q[DVD_W-2:0], ge};
      rem_d = ge ? rem_sub[DSR_W-1:0] : rem_sh[DSR_W-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;

endmodule

[hdl/frwa_regs.sv]
// ----------------------------------------------------------------------------
// frwa_regs
// APB configuration registers: window, step limit, initial and minimum rate.
// ----------------------------------------------------------------------------
module frwa_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [frwa_pkg::APB_AW-1:0]   paddr,
  input  logic [frwa_pkg::APB_DW-1:0]   pwdata,
  output logic [frwa_pkg::APB_DW-1:0]   prdata,
  output logic                          pready,
  output frwa_pkg::cfg_t                cfg_o
);
  import frwa_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  // Registers sit at 8-byte spacing
  assign idx    = reg_idx_e'(paddr[APB_AW-1:3]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  // Write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_WINDOW:    cfg_d.window_blocks = pwdata[CFG_WIN_W-1:0];
        REG_MAX_STEP:  cfg_d.max_run_step  = pwdata[MAX_W-1:0];
        REG_INIT_RATE: cfg_d.initial_rate  = pwdata[RATE_W-1:0];
        REG_MIN_RATE:  cfg_d.minimum_rate  = pwdata[RATE_W-1:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  // Read mux
  always_comb begin
    unique case (idx)
      REG_WINDOW:    prdata = APB_DW'(cfg_q.window_blocks);
      REG_MAX_STEP:  prdata = APB_DW'(cfg_q.max_run_step);
      REG_INIT_RATE: prdata = APB_DW'(cfg_q.initial_rate);
      REG_MIN_RATE:  prdata = APB_DW'(cfg_q.minimum_rate);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window_blocks <= WINDOW_RST;
      cfg_q.max_run_step  <= MAX_STEP_RST;
      cfg_q.initial_rate  <= INIT_RST;
      cfg_q.minimum_rate  <= MIN_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[hdl/frwa_core.sv]
// ----------------------------------------------------------------------------
// frwa_core
// Sequencer: computes the block step, writes it to the step ring, walks the
// window through the ring read port, averages, adjusts and floors the rate.
// ----------------------------------------------------------------------------
module frwa_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  frwa_pkg::cfg_t      cfg_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  frwa_pkg::in_req_t   in_req_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output frwa_pkg::out_rsp_t  out_rsp_o
);
  import frwa_pkg::*;

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_DIV_STEP = 4'd1;
  localparam logic [3:0] ST_WRITE    = 4'd2;
  localparam logic [3:0] ST_READ     = 4'd3;
  localparam logic [3:0] ST_DIV_AVG  = 4'd4;
  localparam logic [3:0] ST_CMP_LOAD = 4'd5;
  localparam logic [3:0] ST_CMP_DEC  = 4'd6;
  localparam logic [3:0] ST_ADJ      = 4'd7;
  localparam logic [3:0] ST_FLOOR    = 4'd8;
  localparam logic [3:0] ST_DONE     = 4'd9;

  logic [3:0]        state_q, state_d;
  in_req_t           req_q, req_d;
  logic [WIN_W-1:0]  win_q, win_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [SLOT_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [WIN_W-1:0]  issue_cnt_q, issue_cnt_d;
  logic              rvalid_q, rvalid_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [SUM_W-1:0]  avg_q, avg_d;
  logic [CMP_W-1:0]  a4_q, a4_d, m3_q, m3_d, a20_q, a20_d, m17_q, m17_d;
  logic [RATE_W-1:0] q10_q, q10_d;
  logic [RATE_W-1:0] next_q, next_d;
  action_e           act_q, act_d;
  logic              hit_q, hit_d;
  logic              out_valid_q, out_valid_d;
  out_rsp_t          out_rsp_q, out_rsp_d;

  logic              ram_we;
  logic [STEP_W-1:0] ram_rdata;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  logic              issuing;
  logic [HEIGHT_W:0] short_lim;
  logic              short_chain;
  logic [2*RATE_W-1:0] recip_prod;
  logic [RATE_W-1:0] q10_x10;
  logic              rem_nz;
  logic [RATE_W-1:0] rate_low;
  logic [RATE_W:0]   rate_high;

  // Step ring
  frwa_ram #(
    .WIDTH (STEP_W),
    .DEPTH (WINDOW_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot_q),
    .wdata_i (step_q),
    .raddr_i (rd_ptr_q),
    .rdata_o (ram_rdata)
  );

  // Shared serial divider
  frwa_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Short chain: 2*window + 1 >= height
  assign short_lim   = (HEIGHT_W+1)'({win_q, 1'b1});
  assign short_chain = short_lim >= {1'b0, req_q.block_height};
  assign issuing     = issue_cnt_q != win_q;

  // rate / 10 by reciprocal multiply (registered in q10_q)
  assign recip_prod = {{RATE_W{1'b0}}, req_q.block_rate} * {{RATE_W{1'b0}}, RECIP10};

  // floor(9r/10) = r - ceil(r/10), floor(11r/10) = r + floor(r/10)
  assign q10_x10   = {q10_q[RATE_W-4:0], 3'b0} + {q10_q[RATE_W-2:0], 1'b0};
  assign rem_nz    = q10_x10 != req_q.block_rate;
  assign rate_low  = req_q.block_rate - q10_q - RATE_W'(rem_nz);
  assign rate_high = {1'b0, req_q.block_rate} + {1'b0, q10_q};

  assign in_ready_o = (state_q == ST_IDLE);

  // Sequencer
  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    win_d       = win_q;
    step_d      = step_q;
    slot_d      = slot_q;
    rd_ptr_d    = rd_ptr_q;
    issue_cnt_d = issue_cnt_q;
    rvalid_d    = 1'b0;
    sum_d       = sum_q;
    avg_d       = avg_q;
    a4_d        = a4_q;
    m3_d        = m3_q;
    a20_d       = a20_q;
    m17_d       = m17_q;
    q10_d       = q10_q;
    next_d      = next_q;
    act_d       = act_q;
    hit_d       = hit_q;
    out_valid_d = out_valid_q;
    out_rsp_d   = out_rsp_q;
    ram_we      = 1'b0;
    div_req     = '0;

    // Output register drains independently
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          req_d = in_req_i;
          win_d = eff_window(cfg_i.window_blocks);
          hit_d = 1'b0;
          if (in_req_i.block_rate == '0) begin
            step_d  = '0;
            state_d = ST_WRITE;
          end else begin
            div_req.start    = 1'b1;
            div_req.dividend = DVD_W'(in_req_i.block_fuel);
            div_req.divisor  = in_req_i.block_rate;
            state_d          = ST_DIV_STEP;
          end
        end
      end

      ST_DIV_STEP: begin
        if (div_rsp.done) begin
          step_d  = times100(div_rsp.quot[RATE_W-1:0]);
          state_d = ST_WRITE;
        end
      end

      // Store the step, then the window walk starts at this same slot
      ST_WRITE: begin
        ram_we      = 1'b1;
        slot_d      = (slot_q == SLOT_W'(WINDOW_DEPTH - 1)) ? '0 : slot_q + 1'b1;
        rd_ptr_d    = slot_q;
        issue_cnt_d = '0;
        sum_d       = '0;
        if (short_chain) begin
          next_d  = cfg_i.initial_rate;
          act_d   = ACT_INITIAL;
          state_d = ST_DONE;
        end else begin
          state_d = ST_READ;
        end
      end

      // One ring read issued per cycle, its data summed in the next cycle
      ST_READ: begin
        if (issuing) begin
          rd_ptr_d    = (rd_ptr_q == '0) ? SLOT_W'(WINDOW_DEPTH - 1) : rd_ptr_q - 1'b1;
          issue_cnt_d = issue_cnt_q + 1'b1;
          rvalid_d    = 1'b1;
        end
        if (rvalid_q) begin
          sum_d = sum_q + SUM_W'(ram_rdata);
        end
        if (!issuing && !rvalid_q) begin
          div_req.start    = 1'b1;
          div_req.dividend = sum_q;
          div_req.divisor  = DSR_W'(win_q);
          state_d          = ST_DIV_AVG;
        end
      end

      ST_DIV_AVG: begin
        if (div_rsp.done) begin
          avg_d   = div_rsp.quot;
          state_d = ST_CMP_LOAD;
        end
      end

      // Threshold terms: 4*avg, 3*max, 20*avg, 17*max; rate / 10
      ST_CMP_LOAD: begin
        a4_d    = CMP_W'({avg_q, 2'b0});
        m3_d    = CMP_W'({cfg_i.max_run_step, 1'b0}) + CMP_W'(cfg_i.max_run_step);
        a20_d   = CMP_W'({avg_q, 4'b0}) + CMP_W'({avg_q, 2'b0});
        m17_d   = CMP_W'({cfg_i.max_run_step, 4'b0}) + CMP_W'(cfg_i.max_run_step);
        q10_d   = RATE_W'(recip_prod >> RECIP10_SH);
        state_d = ST_CMP_DEC;
      end

      ST_CMP_DEC: begin
        if (a4_q < m3_q) begin
          act_d   = ACT_LOWERED;
          state_d = ST_ADJ;
        end else if (a20_q > m17_q) begin
          act_d   = ACT_RAISED;
          state_d = ST_ADJ;
        end else begin
          act_d   = ACT_KEPT;
          next_d  = req_q.block_rate;
          state_d = ST_FLOOR;
        end
      end

      // 9/10 or 11/10; the raised rate saturates at 32 bits
      ST_ADJ: begin
        if (act_q == ACT_LOWERED) begin
          next_d = rate_low;
        end else if (rate_high[RATE_W]) begin
          next_d = '1;
        end else begin
          next_d = rate_high[RATE_W-1:0];
        end
        state_d = ST_FLOOR;
      end

      ST_FLOOR: begin
        if (next_q < cfg_i.minimum_rate) begin
          next_d = cfg_i.minimum_rate;
          hit_d  = 1'b1;
        end
        state_d = ST_DONE;
      end

      // Hand over once the output register is free
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_rsp_d.next_rate   = next_q;
          out_rsp_d.rate_action = act_q;
          out_rsp_d.hit_minimum = hit_q;
          out_valid_d           = 1'b1;
          state_d               = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      slot_q      <= '0;
      issue_cnt_q <= '0;
      rvalid_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      slot_q      <= slot_d;
      issue_cnt_q <= issue_cnt_d;
      rvalid_q    <= rvalid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q     <= req_d;
    win_q     <= win_d;
    step_q    <= step_d;
    rd_ptr_q  <= rd_ptr_d;
    sum_q     <= sum_d;
    avg_q     <= avg_d;
    a4_q      <= a4_d;
    m3_q      <= m3_d;
    a20_q     <= a20_d;
    m17_q     <= m17_d;
    q10_q     <= q10_d;
    next_q    <= next_d;
    act_q     <= act_d;
    hit_q     <= hit_d;
    out_rsp_q <= out_rsp_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

[hdl/fuel_rate_window_adjust_top.sv]
// ----------------------------------------------------------------------------
// fuel_rate_window_adjust_top
// Fuel rate window adjuster. Feed chain blocks in order from genesis; each
// request yields exactly one result with the rate for the following block.
// The block works on one request at a time, and takes the next one only
// once its sequencer is back in the idle state. A short chain skips the
// window walk and the average division, and a zero rate skips the step
// division. A request's duration is set by the shared serial divider, used
// up to twice per request (step and window average), and by the single
// read port of the step ring, which is walked one entry per cycle; the
// 9/10 and 11/10 adjustment uses a reciprocal multiply.
// A finished result waits in an output register, and the next request is
// taken while it waits. The step ring needs no clearing after reset; blocks
// must be fed from genesis so the window only covers written entries.
// Configuration must be written over APB only while no request is in
// flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module fuel_rate_window_adjust_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  frwa_pkg::in_req_t             in_req_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output frwa_pkg::out_rsp_t            out_rsp_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [frwa_pkg::APB_AW-1:0]   paddr,
  input  logic [frwa_pkg::APB_DW-1:0]   pwdata,
  output logic [frwa_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);
  import frwa_pkg::*;

  cfg_t cfg;

  // Configuration registers
  frwa_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Ring, divider and sequencer
  frwa_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

endmodule

[hdl/frwa_checker.sv]
// ----------------------------------------------------------------------------
// frwa_checker
// Port-level checks of the fuel rate window adjuster, bound to the top level.
// ----------------------------------------------------------------------------
module frwa_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_o,
  input  frwa_pkg::in_req_t             in_req_i,
  input  logic                          out_valid_o,
  input  logic                          out_ready_i,
  input  frwa_pkg::out_rsp_t            out_rsp_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [frwa_pkg::APB_AW-1:0]   paddr,
  input  logic [frwa_pkg::APB_DW-1:0]   pwdata,
  input  logic [frwa_pkg::APB_DW-1:0]   prdata,
  input  logic                          pready
);
  import frwa_pkg::*;

  logic [1:0] pend_q;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid_i & in_ready_o;
  assign out_acc = out_valid_o & out_ready_i;

  // Requests accepted but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (in_acc && !out_acc) begin
      pend_q <= pend_q + 1'b1;
    end else if (out_acc && !in_acc) begin
      pend_q <= pend_q - 1'b1;
    end
  end

  a_pready_high: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready dropped");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_o)
    else $error("request taken while another is being worked on");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("stalled result changed");

  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o || pend_q != 2'd0) && pend_q != 2'd3)
    else $error("result without a matching request or too many in flight");

  a_initial_no_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.rate_action == ACT_INITIAL |-> !out_rsp_o.hit_minimum)
    else $error("floor flagged on an initial-rate result");

endmodule

bind fuel_rate_window_adjust_top frwa_checker u_frwa_checker (.*);

[tb/tb_fuel_rate_window_adjust_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fuel_rate_window_adjust_top
// Feeds chain blocks to the fuel rate window adjuster and checks each result
// against a cycle-free predictor kept in the bench (step ring, window average,
// lower/raise/keep thresholds, minimum floor). A short directed run hits the
// threshold edges and corner rates, then random chain segments run under a
// series of register settings written over APB between drained phases.
// ----------------------------------------------------------------------------
module tb_fuel_rate_window_adjust_top;
  import frwa_pkg::*;

  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned PHASE_REQS  = 215;

  // Clock and reset
  logic clk_i;
  logic rst_ni = 1'b0;

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // DUT ports
  logic                in_valid  = 1'b0;
  logic                in_ready;
  in_req_t             in_req    = '0;
  logic                out_valid;
  logic                out_ready = 1'b1;
  out_rsp_t            out_rsp;
  logic                psel      = 1'b0;
  logic                penable   = 1'b0;
  logic                pwrite    = 1'b0;
  logic [APB_AW-1:0]   paddr     = '0;
  logic [APB_DW-1:0]   pwdata    = '0;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  fuel_rate_window_adjust_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_rsp_o   (out_rsp),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // Predictor copy of the registers and the step ring
  logic [CFG_WIN_W-1:0] win_cfg  = WINDOW_RST;
  logic [MAX_W-1:0]     max_cfg  = MAX_STEP_RST;
  logic [RATE_W-1:0]    init_cfg = INIT_RST;
  logic [RATE_W-1:0]    min_cfg  = MIN_RST;
  logic [STEP_W-1:0]    step_ring [WINDOW_DEPTH];
  logic [SLOT_W-1:0]    ring_slot = '0;

  // Bench bookkeeping
  in_req_t      block_q[$];
  out_rsp_t     rate_expect_q[$];
  int           fed_cnt      = 0;
  int           fail_cnt     = 0;
  int unsigned  quiet_cycles = 0;
  logic         in_taken     = 1'b0;
  bit           calm         = 1'b0;
  int unsigned  send_gap     = 0;
  int unsigned  rdy_hold     = 0;

  // Window register clamped to 1..depth
  function automatic int unsigned active_window();
    if (win_cfg == '0) begin
      return 1;
    end
    if (win_cfg > WINDOW_DEPTH) begin
      return WINDOW_DEPTH;
    end
    return int'(win_cfg);
  endfunction

  // Expected result for one block; updates the step ring
  function automatic out_rsp_t predict_next_rate(input in_req_t blk);
    longint unsigned step;
    longint unsigned total;
    longint unsigned avg;
    longint unsigned next_val;
    longint unsigned rate;
    longint unsigned max_step;
    int unsigned     win;
    logic [SLOT_W-1:0] slot;
    out_rsp_t        rsp;
    win      = active_window();
    rate     = 64'(blk.block_rate);
    max_step = 64'(max_cfg);
    step     = 0;
    if (rate != 0) begin
      step = (64'(blk.block_fuel) / rate) * 100;
    end
    slot = ring_slot;
    step_ring[slot] = STEP_W'(step);
    ring_slot = slot + 1'b1;
    rsp.hit_minimum = 1'b0;

    // short chain: no floor, initial rate
    if (longint'(2 * win) >= longint'(64'(blk.block_height)) - 1) begin
      rsp.next_rate   = init_cfg;
      rsp.rate_action = ACT_INITIAL;
      return rsp;
    end

    total = 0;
    for (int i = 0; i < win; i++) begin
      total += 64'(step_ring[SLOT_W'(slot - i)]);
    end
    avg = total / win;

    if (4 * avg < 3 * max_step) begin
      next_val        = (rate * 9) / 10;
      rsp.rate_action = ACT_LOWERED;
    end else if (20 * avg > 17 * max_step) begin
      next_val = (rate * 11) / 10;
      if (next_val > 64'hFFFF_FFFF) begin
        next_val = 64'hFFFF_FFFF;
      end
      rsp.rate_action = ACT_RAISED;
    end else begin
      next_val        = rate;
      rsp.rate_action = ACT_KEPT;
    end

    if (next_val < 64'(min_cfg)) begin
      next_val        = 64'(min_cfg);
      rsp.hit_minimum = 1'b1;
    end
    rsp.next_rate = next_val[RATE_W-1:0];
    return rsp;
  endfunction

  // Random block whose run step sits near pct/100 of max_run_step
  function automatic in_req_t chain_block(input logic [HEIGHT_W-1:0] height,
                                          input int unsigned pct);
    in_req_t         blk;
    longint unsigned q;
    longint unsigned rate_cap;
    longint unsigned rate;
    blk.block_height = height;
    if ($urandom_range(6, 0) == 0) begin
      // noise: any fuel, any rate including zero
      blk.block_fuel = $urandom;
      blk.block_rate = ($urandom_range(9, 0) == 0) ? '0 : RATE_W'($urandom);
      return blk;
    end
    q = (64'(max_cfg) * pct) / 10000;
    if (q > 64'hFFFF_FFFE) begin
      q = 64'hFFFF_FFFE;
    end
    rate_cap = 64'hFFFF_FFFF / (q + 1);
    if ($urandom_range(1, 0) == 0 && rate_cap > 1000) begin
      rate_cap = 1000;
    end
    rate = $urandom_range(32'(rate_cap), 1);
    blk.block_rate = RATE_W'(rate);
    blk.block_fuel = RATE_W'(q * rate + $urandom_range(32'(rate - 1), 0));
    return blk;
  endfunction

  // Queue a block; while the ring is still filling, keep averaging on
  // written entries only by turning the block into a short-chain one
  task automatic queue_block(input in_req_t blk);
    if (fed_cnt + 1 < active_window() &&
        64'(blk.block_height) > 64'(2 * active_window() + 1)) begin
      blk.block_height = HEIGHT_W'(2 * active_window() + 1);
    end
    block_q.insert(block_q.size(), blk);
    fed_cnt++;
  endtask

  // APB write: setup then access phase
  task automatic cfg_write(input reg_idx_e idx, input logic [APB_DW-1:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'({idx, 3'b000});
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) begin
      @(posedge clk_i);
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_WINDOW:    win_cfg  = value[CFG_WIN_W-1:0];
      REG_MAX_STEP:  max_cfg  = value[MAX_W-1:0];
      REG_INIT_RATE: init_cfg = value[RATE_W-1:0];
      REG_MIN_RATE:  min_cfg  = value[RATE_W-1:0];
      default: ;
    endcase
  endtask

  // Hold until every queued request is taken and every result is back
  task automatic wait_chain_idle();
    @(posedge clk_i);
    while (block_q.size() != 0 || in_valid || rate_expect_q.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // Request driver with random gaps
  always @(negedge clk_i) begin
    if (rst_ni && !(in_valid && !in_taken)) begin
      if (send_gap != 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (block_q.size() != 0) begin
        if (!calm && $urandom_range(3, 0) == 0) begin
          send_gap <= $urandom_range(8, 0);
          in_valid <= 1'b0;
        end else begin
          in_req   <= block_q.pop_front();
          in_valid <= 1'b1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result ready with stall bursts and open stretches
  always @(negedge clk_i) begin
    if (rdy_hold != 0) begin
      rdy_hold <= rdy_hold - 1;
    end else if (!calm && $urandom_range(3, 0) == 0) begin
      out_ready <= 1'b0;
      rdy_hold  <= $urandom_range(8, 0);
    end else begin
      out_ready <= 1'b1;
      rdy_hold  <= calm ? 0 : $urandom_range(19, 0);
    end
  end

  // Predict on accepted requests, compare accepted results
  always @(posedge clk_i) begin : check_results
    out_rsp_t want;
    in_taken <= in_valid && in_ready;
    if (rst_ni) begin
      if (in_valid && in_ready) begin
        rate_expect_q.insert(rate_expect_q.size(), predict_next_rate(in_req));
      end
      if (out_valid && out_ready) begin
        if (rate_expect_q.size() == 0) begin
          $error("result with no request pending: next_rate %0d", out_rsp.next_rate);
          fail_cnt++;
        end else begin
          want = rate_expect_q.pop_front();
          if (out_rsp.next_rate !== want.next_rate) begin
            $error("next_rate expected %0d actual %0d", want.next_rate, out_rsp.next_rate);
            fail_cnt++;
          end
          if (out_rsp.rate_action !== want.rate_action) begin
            $error("rate_action expected %0d actual %0d",
                   want.rate_action, out_rsp.rate_action);
            fail_cnt++;
          end
          if (out_rsp.hit_minimum !== want.hit_minimum) begin
            $error("hit_minimum expected %0d actual %0d",
                   want.hit_minimum, out_rsp.hit_minimum);
            fail_cnt++;
          end
        end
      end
    end
  end

  // Watchdog on cycles with no handshake on either side
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stimulus
  initial begin
    int unsigned      n;
    int unsigned      seg_len;
    int unsigned      center;
    logic [HEIGHT_W-1:0] base;

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings, window 50: short chain, zero rate, boundary height
    queue_block(in_req_t'{31'd0,   32'hFFFF_FFFF, 32'd0});
    queue_block(in_req_t'{31'd1,   32'hFFFF_FFFF, 32'd1});
    queue_block(in_req_t'{31'd101, 32'd0,         32'hFFFF_FFFF});
    wait_chain_idle();

    // Window 0 acts as 1: threshold edges against max 12e6
    cfg_write(REG_WINDOW, '0);
    @(posedge clk_i);
    queue_block(in_req_t'{31'd3,  32'd5,           32'd5});
    queue_block(in_req_t'{31'd4,  32'd0,           32'd5});
    queue_block(in_req_t'{31'd5,  32'd100_000_000, 32'd1000});
    queue_block(in_req_t'{31'd6,  32'd90_000_000,  32'd1000});
    queue_block(in_req_t'{31'd7,  32'd89_999_000,  32'd1000});
    queue_block(in_req_t'{31'd8,  32'd102_000_000, 32'd1000});
    queue_block(in_req_t'{31'd9,  32'd102_001_000, 32'd1000});
    queue_block(in_req_t'{31'd10, 32'd0,           32'd1});
    queue_block(in_req_t'{31'd11, 32'd0,           32'd0});
    queue_block(in_req_t'{31'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
    queue_block(in_req_t'{31'd12, 32'd4_000_000_000, 32'd20_000});
    wait_chain_idle();

    // Tiny max: raise saturation, zero floor
    cfg_write(REG_MAX_STEP, 64'd1);
    cfg_write(REG_MIN_RATE, '0);
    cfg_write(REG_INIT_RATE, 64'hFFFF_FFFF);
    cfg_write(REG_WINDOW, 64'd1);
    @(posedge clk_i);
    queue_block(in_req_t'{31'd0,  32'd0,           32'd7});
    queue_block(in_req_t'{31'd20, 32'hFFFF_FFFF,   32'hFFFF_FFFF});
    queue_block(in_req_t'{31'd21, 32'd0,           32'd0});
    queue_block(in_req_t'{31'd22, 32'd0,           32'd10});
    wait_chain_idle();

    // Huge max and top floor: every adjusted rate clamps to minimum
    cfg_write(REG_MAX_STEP, 64'hFF_FFFF_FFFF);
    cfg_write(REG_MIN_RATE, 64'hFFFF_FFFF);
    cfg_write(REG_INIT_RATE, '0);
    @(posedge clk_i);
    queue_block(in_req_t'{31'd1,  32'd0,           32'd9});
    queue_block(in_req_t'{31'd50, 32'd1000,        32'd3});
    queue_block(in_req_t'{31'd51, 32'hFFFF_FFFF,   32'd1});

    // Random phases, each with its own register settings
    for (int ph = 0; ph < 8; ph++) begin
      wait_chain_idle();
      case (ph)
        0:       cfg_write(REG_WINDOW, 64'd127);
        1:       cfg_write(REG_WINDOW, 64'd64);
        3:       cfg_write(REG_WINDOW, 64'd1);
        4:       cfg_write(REG_WINDOW, '0);
        6:       cfg_write(REG_WINDOW, 64'($urandom_range(126, 65)));
        7:       cfg_write(REG_WINDOW, 64'($urandom_range(64, 1)));
        default: cfg_write(REG_WINDOW, 64'($urandom_range(63, 2)));
      endcase
      case (ph)
        1:       cfg_write(REG_MAX_STEP, 64'hFF_FFFF_FFFF);
        3:       cfg_write(REG_MAX_STEP, 64'd1);
        5:       cfg_write(REG_MAX_STEP, {24'd0, 8'($urandom), 32'($urandom)});
        default: cfg_write(REG_MAX_STEP, 64'($urandom_range(50_000_000, 1000)));
      endcase
      case (ph)
        0:       cfg_write(REG_INIT_RATE, '0);
        2:       cfg_write(REG_INIT_RATE, 64'hFFFF_FFFF);
        default: cfg_write(REG_INIT_RATE, 64'($urandom));
      endcase
      case (ph)
        1:       cfg_write(REG_MIN_RATE, 64'hFFFF_FFFF);
        4:       cfg_write(REG_MIN_RATE, '0);
        6:       cfg_write(REG_MIN_RATE, 64'($urandom));
        default: cfg_write(REG_MIN_RATE, 64'($urandom_range(1000, 0)));
      endcase
      @(posedge clk_i);
      calm = (ph == 7);

      // Chain segments: consecutive heights, step level around a center
      n = 0;
      while (n < PHASE_REQS) begin
        seg_len = $urandom_range(40, 1);
        center  = $urandom_range(105, 55);
        if ($urandom_range(9, 0) < 2) begin
          base = HEIGHT_W'($urandom_range(2 * active_window() + 3, 0));
        end else begin
          base = HEIGHT_W'($urandom_range(32'h7FFF_FFBF, 0));
        end
        for (int k = 0; k < seg_len; k++) begin
          queue_block(chain_block(base + HEIGHT_W'(k), center + $urandom_range(20, 0) - 10));
          n++;
        end
      end
    end

    wait_chain_idle();
    repeat (300) @(posedge clk_i);
    if (fail_cnt == 0 && rate_expect_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[fuel_rate_window_adjust_top.f]
hdl/frwa_pkg.sv
hdl/frwa_ram.sv
hdl/frwa_div.sv
hdl/frwa_regs.sv
hdl/frwa_core.sv
hdl/fuel_rate_window_adjust_top.sv
hdl/frwa_checker.sv
tb/tb_fuel_rate_window_adjust_top.sv
